// ===== rtl/ial_pkg.sv =====
// Package for the indexed array list: command codes, status codes, field
// widths and the control bundle that the list drives into every cell.
// No dependencies.
package ial_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 7;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_LOCATE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic {
    ST_OK     = 1'b0,
    ST_REJECT = 1'b1
  } status_e;

  // Per-cell control for one accepted item.
  typedef struct packed {
    logic ins;     // accepted insert
    logic del;     // accepted delete
    logic locate;  // locate command
    logic at;      // this cell is at the addressed position
    logic above;   // this cell lies above the addressed position
    logic valid;   // this cell lies below the current length
  } cell_ctl_t;

endpackage

// ===== rtl/ial_cell.sv =====
// One storage cell of the list: holds one entry, shifts with its neighbors
// on insert and delete, and registers its own match for locate.
// Depends on ial_pkg.
module ial_cell import ial_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0] entry_o,
  output logic                     match_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic                     match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && ctl_i.at) begin
      entry_d = value_i;
    end else if (ctl_i.ins && ctl_i.above) begin
      entry_d = left_i;
    end else if (ctl_i.del && (ctl_i.at || ctl_i.above)) begin
      entry_d = right_i;
    end
    match_d = ctl_i.locate && ctl_i.valid && (entry_q == value_i);
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== rtl/ial_first.sv =====
// Priority encoder over the registered match bits of the cells: reports
// whether any bit is set and the index of the lowest one.
// Depends on ial_pkg.
module ial_first import ial_pkg::*; #(
  parameter int N = 64
) (
  input  logic [N-1:0]         match_i,
  output logic                 any_o,
  output logic [$clog2(N)-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (match_i[k]) begin
        idx_o = ($clog2(N))'(k);
      end
    end
    any_o = |match_i;
  end

endmodule

// ===== rtl/indexed_array_list.sv =====
// Indexed array list: an ordered list of signed 32-bit entries in a row of cells.
// The result of an item is strobed on done_o in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, as every cell shifts or compares at once.
// Reset clears the length and the result strobe; the entries are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_array_list import ial_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               command_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic                     status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                     found_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic [LEN_W-1:0]         length_o
);

  // Widths derived from the capacity. XW is wide enough for both a position
  // and the count, so that range checks compare like with like.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  // Only positions 0 to 63 can be addressed, so a get reads among these.
  localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  // The cells work on every item at once, so no item ever waits.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [CW-1:0] count_q, count_d;
  logic [XW-1:0] pos_x, count_x;
  logic          ok;
  logic          do_ins, do_del, is_locate;
  logic signed [DATA_W-1:0] rd_sel;

  assign pos_x   = XW'(position_i);
  assign count_x = XW'(count_q);

  // Command decode: range checks and the length after the command. A
  // rejected command leaves the count and every cell untouched.
  always_comb begin
    ok        = 1'b0;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    is_locate = 1'b0;
    count_d   = count_q;
    case (cmd_e'(command_i))
      CMD_GET: begin
        ok = pos_x < count_x;
      end
      CMD_LOCATE: begin
        ok        = 1'b1;
        is_locate = 1'b1;
      end
      CMD_INSERT: begin
        ok     = (count_q != CW'(CAPACITY)) && (pos_x <= count_x);
        do_ins = ok;
        if (ok) begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_DELETE: begin
        ok     = pos_x < count_x;
        do_del = ok;
        if (ok) begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_CLEAR: begin
        ok      = 1'b1;
        count_d = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // The row of cells. Each cell takes its lower neighbor's entry when an
  // insert opens a gap below it and its upper neighbor's entry when a
  // delete closes one. The bottom cell never shifts up and the top cell
  // keeps its own entry on a delete, since that slot falls out of the list.
  cell_ctl_t                ctl     [CAPACITY];
  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]      match;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;

    assign ctl[k].ins    = accept && do_ins;
    assign ctl[k].del    = accept && do_del;
    assign ctl[k].locate = accept && is_locate;
    assign ctl[k].at     = pos_x == XW'(k);
    assign ctl[k].above  = XW'(k) > pos_x;
    assign ctl[k].valid  = XW'(k) < count_x;

    if (k == 0) begin : g_bottom
      assign left = value_i;
    end else begin : g_left
      assign left = entries[k-1];
    end
    if (k == CAPACITY - 1) begin : g_top
      assign right = entries[k];
    end else begin : g_right
      assign right = entries[k+1];
    end

    ial_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[k]),
      .left_i  (left),
      .right_i (right),
      .value_i (value_i),
      .entry_o (entries[k]),
      .match_o (match[k])
    );
  end

  // Read port for get: selects the addressed entry before the cells change.
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (pos_x == XW'(k)) begin
        rd_sel = entries[k];
      end
    end
  end

  // Result stage. The match bits were captured by the cells at the same edge.
  logic                     done_q;
  logic                     status_q;
  logic signed [DATA_W-1:0] rd_q;
  logic                     locate_q;
  logic [LEN_W-1:0]         len_q;
  logic [LW-1:0]            len_x;

  assign len_x = LW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= ok ? ST_OK : ST_REJECT;
      rd_q     <= (ok && (cmd_e'(command_i) == CMD_GET)) ? rd_sel : '0;
      locate_q <= is_locate;
      len_q    <= len_x[LEN_W-1:0];
    end
  end

  // Lowest matching cell for locate.
  logic          any_match;
  logic [IW-1:0] first_idx;
  logic [XW-1:0] first_x;

  ial_first #(.N(CAPACITY)) u_first (
    .match_i (match),
    .any_o   (any_match),
    .idx_o   (first_idx)
  );

  assign first_x = XW'(first_idx);

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = rd_q;
  assign found_o          = locate_q && any_match;
  assign found_position_o = (locate_q && any_match) ? first_x[POS_W-1:0] : '0;
  assign length_o         = len_q;

  // The length never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  // A result strobe follows in the cycle after an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> done_o)
    else $error("accepted item produced no result");

  // A rejected command leaves the length unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (count_q == $past(count_q)))
    else $error("rejected command changed the length");

  // Only an accepted locate reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (done_o && !status_o))
    else $error("match reported outside a locate result");

endmodule

// ===== sim/tb_indexed_array_list.sv =====
// Self-checking testbench for indexed_array_list: directed and random commands
// against an in-bench model of the ordered list, one result per command.
// Depends on ial_pkg and the indexed_array_list RTL.
module tb_indexed_array_list import ial_pkg::*;;

  localparam int LIST_DEPTH = 64;
  localparam int ITEM_GOAL  = 900;
  // Codes 5 to 7 carry no command; the list must reject them.
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_MID_UNUSED   = 3'd6;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LIST_DEPTH - 1);

  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_NEG1 = 32'shFFFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_ZERO = 32'sh0000_0000;

  // One result as the list reports it.
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [POS_W-1:0]         found_position;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  // Scoreboard: keeps its own copy of the list, works out the result of every
  // accepted command and holds it until the matching strobe arrives.
  class list_scoreboard;
    logic signed [DATA_W-1:0] cells[LIST_DEPTH];
    int unsigned              len;
    list_result_t             pending_results[$];
    int                       errors;
    int                       checked;
    int                       per_command[8];
    int                       rejects;
    int                       hits;
    int unsigned              peak_len;

    function new();
      len      = 0;
      errors   = 0;
      checked  = 0;
      rejects  = 0;
      hits     = 0;
      peak_len = 0;
      foreach (per_command[i]) per_command[i] = 0;
    endfunction

    // Applies one accepted command to the model and queues its result.
    function void note_command(logic [2:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t r;
      int unsigned  p;
      p = 32'(pos);
      r = '{status: ST_OK, read_value: '0, found: 1'b0, found_position: '0,
            length: '0};
      case (cmd)
        CMD_GET: begin
          if (p < len) r.read_value = cells[p];
          else r.status = ST_REJECT;
        end
        CMD_LOCATE: begin
          // The lowest matching position wins, so stop at the first hit.
          for (int k = 0; k < len; k++) begin
            if (cells[k] === val) begin
              r.found          = 1'b1;
              r.found_position = k[POS_W-1:0];
              break;
            end
          end
        end
        CMD_INSERT: begin
          if (len >= LIST_DEPTH || p > len) begin
            r.status = ST_REJECT;
          end else begin
            for (int k = len; k > p; k--) cells[k] = cells[k-1];
            cells[p] = val;
            len++;
          end
        end
        CMD_DELETE: begin
          if (p >= len) begin
            r.status = ST_REJECT;
          end else begin
            for (int k = p + 1; k < len; k++) cells[k-1] = cells[k];
            len--;
          end
        end
        CMD_CLEAR: len = 0;
        default: r.status = ST_REJECT;
      endcase
      r.length = len[LEN_W-1:0];
      if (r.status == ST_REJECT) rejects++;
      if (r.found) hits++;
      if (len > peak_len) peak_len = len;
      per_command[cmd]++;
      pending_results.push_back(r);
    endfunction

    function void check_field(string field, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                 $time, field, want, got);
        errors++;
      end
    endfunction

    // Compares one strobed result with the oldest expectation.
    function void check_result(logic status, logic signed [DATA_W-1:0] rd,
                               logic fnd, logic [POS_W-1:0] fpos,
                               logic [LEN_W-1:0] length);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no command outstanding, expected none, actual len %0d",
                 $time, length);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      check_field("status", want.status, status);
      check_field("read_value", want.read_value, rd);
      check_field("found", want.found, fnd);
      check_field("found_position", want.found_position, fpos);
      check_field("length", want.length, length);
    endfunction
  endclass

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start      = 1'b0;
  logic [2:0]               command_i  = CMD_GET;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] value_i    = '0;
  logic                     busy;
  logic                     done_o;
  logic                     status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic                     found_o;
  logic [POS_W-1:0]         found_position_o;
  logic [LEN_W-1:0]         length_o;

  list_scoreboard sb = new();

  // Stimulus-side view of the length, kept so that well-formed positions can
  // be chosen before the command has actually been accepted.
  int unsigned              gen_len = 0;
  int                       issued  = 0;
  bit                       quiet   = 1'b0;
  logic signed [DATA_W-1:0] value_pool[8];

  always #1 clk_i = ~clk_i;

  indexed_array_list #(.CAPACITY(LIST_DEPTH)) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .length_o         (length_o)
  );

  // Monitor. Both checks see the values from before this edge, since the
  // block and the driver only update with nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(status_o, read_value_o, found_o, found_position_o,
                        length_o);
      end
      if (start && !busy) sb.note_command(command_i, position_i, value_i);
    end
  end

  // How the length moves for one command; only used to steer the stimulus.
  function automatic int unsigned length_after(logic [2:0] cmd,
                                               logic [POS_W-1:0] pos,
                                               int unsigned len);
    int unsigned p;
    p = 32'(pos);
    case (cmd)
      CMD_INSERT: return (len < LIST_DEPTH && p <= len) ? len + 1 : len;
      CMD_DELETE: return (p < len) ? len - 1 : len;
      CMD_CLEAR:  return 0;
      default:    return len;
    endcase
  endfunction

  // Drives one item and returns after the edge that takes it. Start is left
  // high, so back-to-back items go in with no gap, but for the random gaps when not quiet.
  task automatic send_command(logic [2:0] cmd, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start      <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gen_len = length_after(cmd, pos, gen_len);
    issued++;
  endtask

  // Half of the values come from a small pool, so that locate hits and duplicate
  // entries are common; the rest are extremes or fully random words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1:    return value_pool[$urandom_range(7)];
      2:       return $urandom;
      default: begin
        case ($urandom_range(3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return VAL_NEG1;
          default: return VAL_ZERO;
        endcase
      end
    endcase
  endfunction

  // Any position at all, in range or not.
  function automatic logic [POS_W-1:0] pick_any_pos();
    return POS_W'($urandom_range(LIST_DEPTH - 1));
  endfunction

  // A position inside the list, or anywhere when the list is empty.
  function automatic logic [POS_W-1:0] pick_valid_pos(int unsigned limit);
    if (limit == 0) return pick_any_pos();
    return POS_W'($urandom_range(limit - 1));
  endfunction

  // A position from 0 up to the length, the legal range for an insert.
  function automatic logic [POS_W-1:0] pick_insert_pos();
    return POS_W'($urandom_range((gen_len > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : gen_len));
  endfunction

  // One command of the mixed phase: mostly legal, some out of range, some
  // clears, reserved codes and raw noise.
  task automatic random_command();
    int unsigned r;
    bit          legal;
    r     = $urandom_range(99);
    legal = ($urandom_range(99) < 85);
    if (r < 30) begin
      send_command(CMD_INSERT, legal ? pick_insert_pos() : pick_any_pos(),
                   pick_value());
    end else if (r < 45) begin
      send_command(CMD_DELETE, legal ? pick_valid_pos(gen_len) : pick_any_pos(),
                   $urandom);
    end else if (r < 65) begin
      send_command(CMD_GET, legal ? pick_valid_pos(gen_len) : pick_any_pos(),
                   $urandom);
    end else if (r < 85) begin
      send_command(CMD_LOCATE, pick_any_pos(), pick_value());
    end else if (r < 88) begin
      send_command(CMD_CLEAR, pick_any_pos(), $urandom);
    end else if (r < 93) begin
      send_command(3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED)),
                   pick_any_pos(), $urandom);
    end else begin
      send_command(3'($urandom_range(CMD_LAST_UNUSED)), pick_any_pos(),
                   $urandom);
    end
  endtask

  initial begin
    int wait_cycles;
    int other_cmds;
    foreach (value_pool[i]) value_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The empty list rejects get, delete and inserts past
    // the end, and locate finds nothing.
    send_command(CMD_GET, POS_W'(0), VAL_ZERO);
    send_command(CMD_DELETE, POS_W'(0), VAL_ZERO);
    send_command(CMD_LOCATE, POS_W'(0), VAL_ZERO);
    send_command(CMD_INSERT, POS_W'(1), VAL_MAX);
    send_command(CMD_INSERT, POS_LAST, VAL_MAX);
    // Build the list from the value extremes, inserting at the front, at the
    // end and in the middle, with a duplicate of -1 at both ends.
    send_command(CMD_INSERT, POS_W'(0), VAL_MAX);
    send_command(CMD_INSERT, POS_W'(1), VAL_MIN);
    send_command(CMD_INSERT, POS_W'(0), VAL_NEG1);
    send_command(CMD_INSERT, POS_W'(1), VAL_ZERO);
    send_command(CMD_INSERT, POS_W'(4), VAL_NEG1);
    // Locate must report the lowest of two matches and compare all 32 bits.
    send_command(CMD_LOCATE, POS_W'(0), VAL_NEG1);
    send_command(CMD_LOCATE, POS_W'(0), VAL_MIN);
    send_command(CMD_LOCATE, POS_W'(0), VAL_MAX - 1);
    // Get at the first and last entry, then just past the end and at the
    // highest position.
    send_command(CMD_GET, POS_W'(0), VAL_ZERO);
    send_command(CMD_GET, POS_W'(4), VAL_ZERO);
    send_command(CMD_GET, POS_W'(5), VAL_ZERO);
    send_command(CMD_GET, POS_LAST, VAL_ZERO);
    // Delete in the middle and at the end, then one past the end.
    send_command(CMD_DELETE, POS_W'(1), VAL_ZERO);
    send_command(CMD_DELETE, POS_W'(3), VAL_ZERO);
    send_command(CMD_DELETE, POS_W'(3), VAL_ZERO);
    // The reserved codes change nothing.
    send_command(CMD_FIRST_UNUSED, POS_W'(0), VAL_MAX);
    send_command(CMD_MID_UNUSED, POS_LAST, VAL_MIN);
    send_command(CMD_LAST_UNUSED, POS_W'(2), VAL_NEG1);
    // Clear empties the list; the old entries must no longer be visible.
    send_command(CMD_CLEAR, POS_LAST, VAL_NEG1);
    send_command(CMD_GET, POS_W'(0), VAL_ZERO);
    send_command(CMD_LOCATE, POS_W'(0), VAL_NEG1);

    // Random part, in phases. A stretch in the middle runs without any gaps.
    while (issued < ITEM_GOAL) begin
      quiet = (issued >= 400 && issued < 560);
      case ($urandom_range(9))
        0, 1, 2: begin
          // Fill up to capacity with reads mixed in, then try to overfill.
          while (gen_len < LIST_DEPTH) begin
            if ($urandom_range(4) == 0) begin
              send_command($urandom_range(1) ? CMD_GET : CMD_LOCATE,
                           pick_valid_pos(gen_len), pick_value());
            end else begin
              send_command(CMD_INSERT, pick_insert_pos(), pick_value());
            end
          end
          send_command(CMD_INSERT, pick_any_pos(), pick_value());
          send_command(CMD_GET, POS_LAST, $urandom);
          send_command(CMD_LOCATE, POS_W'(0), pick_value());
        end
        3, 4: begin
          // Drain to empty, then delete once more.
          while (gen_len > 0) begin
            if ($urandom_range(3) == 0) send_command(CMD_GET, pick_valid_pos(gen_len), $urandom);
            else send_command(CMD_DELETE, pick_valid_pos(gen_len), $urandom);
          end
          send_command(CMD_DELETE, pick_any_pos(), $urandom);
        end
        default: begin
          repeat ($urandom_range(40, 20)) random_command();
        end
      endcase
    end

    // The last item went in at the edge just passed; drop start at once so
    // that it is not taken a second time.
    start <= 1'b0;

    // The last result comes in the cycle after its command was taken.
    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, sb.pending_results.size());
      sb.errors++;
    end

    other_cmds = 0;
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
      other_cmds += sb.per_command[c];
    end
    $display("Ran %0d commands (get %0d, locate %0d, insert %0d, delete %0d, clear %0d, other %0d).",
             issued, sb.per_command[CMD_GET], sb.per_command[CMD_LOCATE],
             sb.per_command[CMD_INSERT], sb.per_command[CMD_DELETE],
             sb.per_command[CMD_CLEAR], other_cmds);
    $display("Checked %0d results: %0d rejected, %0d locate hits, list reached %0d entries.",
             sb.checked, sb.rejects, sb.hits, sb.peak_len);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block stops taking commands.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
